@@ src/ssc_pkg.sv @@
// shared types, constants and command codes of the serial seconds counter rtc
`default_nettype none

package ssc_pkg;

    localparam int unsigned CountWidth = 32;
    localparam int unsigned IndexWidth = 6;
    localparam int unsigned CmdBits    = 8;

    localparam logic [CmdBits-1:0] RW_MASK    = 8'hc1;
    localparam logic [CmdBits-1:0] READ_CODE  = 8'h81;
    localparam logic [CmdBits-1:0] LOAD_CODE0 = 8'h80;
    localparam logic [CmdBits-1:0] LOAD_CODE1 = 8'h40;
    localparam logic [CmdBits-1:0] NOP_CODE   = 8'h41;
    localparam logic [CmdBits-1:0] CLR_MASK   = 8'hc4;
    localparam logic [CmdBits-1:0] CLR_CODE   = 8'h04;

    localparam logic [IndexWidth-1:0] CMD_LAST  = IndexWidth'(CmdBits - 1);
    localparam logic [IndexWidth-1:0] WORD_LAST = IndexWidth'(CountWidth - 1);

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_LOAD  = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        logic second_tick;
        logic reset_level;
        logic clock_level;
        logic drive_data;
        logic data_in;
    } sample_t;

    typedef struct packed {
        logic    step;
        sample_t smp;
    } core_ctrl_t;

endpackage

`default_nettype wire

@@ src/ssc_if.sv @@
// valid/ready channel interfaces for pin samples and data line results
`default_nettype none

interface ssc_sample_if;
    logic valid;
    logic ready;
    logic second_tick;
    logic reset_level;
    logic clock_level;
    logic drive_data;
    logic data_in;

    modport source (
        output valid, second_tick, reset_level, clock_level, drive_data, data_in,
        input  ready
    );
    modport sink (
        input  valid, second_tick, reset_level, clock_level, drive_data, data_in,
        output ready
    );
endinterface

interface ssc_result_if;
    logic valid;
    logic ready;
    logic data_out;

    modport source (
        output valid, data_out,
        input  ready
    );
    modport sink (
        input  valid, data_out,
        output ready
    );
endinterface

`default_nettype wire

@@ src/serial_seconds_counter_rtc.sv @@
// top level of the three-wire serial rtc with a 32-bit seconds counter
`default_nettype none

// Takes one pin sample per clock while not stalled and returns one data
// line beat per sample. A sample is held in an input register, runs through
// the single-pass next-state logic of the core, and its data line level
// lands in the result register, from which the beat is offered once the
// core has stepped on that sample. With result ready held
// high a new sample is accepted every clock. While a result beat is stalled
// the input register can still take one sample, then the input stalls too.
// Write epoch_base only while no sample is in flight.
module serial_seconds_counter_rtc (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    ssc_sample_if.sink                          sample,
    ssc_result_if.source                        result,
    input  wire logic                           cfg_wr_en,
    input  wire logic [ssc_pkg::CountWidth-1:0] cfg_wr_data
);

    logic                           in_valid_reg;
    ssc_pkg::sample_t               in_data_reg;
    logic                           out_valid_reg;
    logic                           out_data_reg;
    logic [ssc_pkg::CountWidth-1:0] base_reg;

    logic                           advance;
    logic                           take_in;
    logic                           line_next;
    ssc_pkg::core_ctrl_t            ctrl;

    assign advance      = in_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !in_valid_reg || advance;
    assign take_in      = sample.valid && sample.ready;

    assign ctrl.step = advance;
    assign ctrl.smp  = in_data_reg;

    ssc_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .epoch_base (base_reg),
        .line_next  (line_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            base_reg      <= '0;
        end
        else
        begin
            if (sample.ready)
            begin
                in_valid_reg <= sample.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr_en)
            begin
                base_reg <= cfg_wr_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_data_reg.second_tick <= sample.second_tick;
            in_data_reg.reset_level <= sample.reset_level;
            in_data_reg.clock_level <= sample.clock_level;
            in_data_reg.drive_data  <= sample.drive_data;
            in_data_reg.data_in     <= sample.data_in;
        end
        if (advance)
        begin
            out_data_reg <= line_next;
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.data_out = out_data_reg;

endmodule

`default_nettype wire

@@ src/ssc_cmd_dec.sv @@
// command byte decoder
`default_nettype none

module ssc_cmd_dec (
    input  wire logic [ssc_pkg::CmdBits-1:0] cmd,
    output ssc_pkg::cmd_kind_t               kind
);

    logic [ssc_pkg::CmdBits-1:0] rw_bits;
    logic [ssc_pkg::CmdBits-1:0] clr_bits;

    assign rw_bits  = cmd & ssc_pkg::RW_MASK;
    assign clr_bits = cmd & ssc_pkg::CLR_MASK;

    always_comb
    begin
        if (rw_bits == ssc_pkg::READ_CODE)
        begin
            kind = ssc_pkg::CMD_READ;
        end
        else if (rw_bits == ssc_pkg::LOAD_CODE0 || rw_bits == ssc_pkg::LOAD_CODE1)
        begin
            kind = ssc_pkg::CMD_LOAD;
        end
        else if (rw_bits == ssc_pkg::NOP_CODE)
        begin
            kind = ssc_pkg::CMD_NONE;
        end
        else if (clr_bits == ssc_pkg::CLR_CODE)
        begin
            kind = ssc_pkg::CMD_CLEAR;
        end
        else
        begin
            kind = ssc_pkg::CMD_NONE;
        end
    end

endmodule

`default_nettype wire

@@ src/ssc_core.sv @@
// counter, serial shift state and next-state logic for one pin sample
`default_nettype none

module ssc_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire ssc_pkg::core_ctrl_t               ctrl,
    input  wire logic [ssc_pkg::CountWidth-1:0]    epoch_base,
    output logic                                   line_next
);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_CMD  = 2'd1,
        PH_READ = 2'd2,
        PH_LOAD = 2'd3
    } phase_t;

    logic [ssc_pkg::CountWidth-1:0] count_reg, count_next;
    logic [ssc_pkg::CountWidth-1:0] shift_reg, shift_next;
    logic [ssc_pkg::IndexWidth-1:0] index_reg, index_next;
    phase_t                         phase_reg, phase_next;
    logic                           last_rst_reg, last_rst_next;
    logic                           last_sck_reg, last_sck_next;
    logic                           line_reg;

    logic                           line_mid;
    logic [ssc_pkg::CmdBits-1:0]    cmd_byte;
    ssc_pkg::cmd_kind_t             cmd_kind;

    // command byte as it stands once the eighth bit is shifted in
    assign line_mid = ctrl.smp.drive_data ? ctrl.smp.data_in : line_reg;
    assign cmd_byte = {line_mid, shift_reg[ssc_pkg::CmdBits-2:0]};

    ssc_cmd_dec u_dec (
        .cmd  (cmd_byte),
        .kind (cmd_kind)
    );

    always_comb
    begin
        count_next    = count_reg;
        shift_next    = shift_reg;
        index_next    = index_reg;
        phase_next    = phase_reg;
        last_rst_next = last_rst_reg;
        last_sck_next = last_sck_reg;
        line_next     = line_reg;

        if (ctrl.smp.second_tick)
        begin
            count_next = count_next + 1'b1;
        end

        if (ctrl.smp.reset_level != last_rst_reg)
        begin
            if (ctrl.smp.reset_level)
            begin
                phase_next = PH_CMD;
                index_next = '0;
                shift_next = '0;
            end
            else
            begin
                phase_next = PH_IDLE;
            end
            last_rst_next = ctrl.smp.reset_level;
        end

        line_next = line_mid;

        if (ctrl.smp.clock_level != last_sck_reg)
        begin
            last_sck_next = ctrl.smp.clock_level;
            if (ctrl.smp.clock_level)
            begin
                unique case (phase_next)
                    PH_CMD:
                    begin
                        shift_next[index_next[2:0]] = shift_next[index_next[2:0]] | line_next;
                        if (index_next == ssc_pkg::CMD_LAST)
                        begin
                            case (cmd_kind)
                                ssc_pkg::CMD_READ:
                                begin
                                    phase_next = PH_READ;
                                    shift_next = count_next - epoch_base;
                                    index_next = '0;
                                end
                                ssc_pkg::CMD_LOAD:
                                begin
                                    phase_next = PH_LOAD;
                                    shift_next = '0;
                                    index_next = '0;
                                end
                                ssc_pkg::CMD_CLEAR:
                                begin
                                    count_next = '0;
                                    phase_next = PH_IDLE;
                                    index_next = index_next + 1'b1;
                                end
                                default:
                                begin
                                    phase_next = PH_IDLE;
                                    index_next = index_next + 1'b1;
                                end
                            endcase
                        end
                        else
                        begin
                            index_next = index_next + 1'b1;
                        end
                    end
                    PH_LOAD:
                    begin
                        shift_next[index_next[4:0]] = shift_next[index_next[4:0]] | line_next;
                        if (index_next == ssc_pkg::WORD_LAST)
                        begin
                            count_next = shift_next;
                            phase_next = PH_IDLE;
                        end
                        index_next = index_next + 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (phase_next == PH_READ)
            begin
                line_next = shift_next[index_next[4:0]];
                if (index_next == ssc_pkg::WORD_LAST)
                begin
                    phase_next = PH_IDLE;
                end
                index_next = index_next + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            shift_reg    <= '0;
            index_reg    <= '0;
            phase_reg    <= PH_IDLE;
            last_rst_reg <= 1'b1;
            last_sck_reg <= 1'b1;
            line_reg     <= 1'b1;
        end
        else if (ctrl.step)
        begin
            count_reg    <= count_next;
            shift_reg    <= shift_next;
            index_reg    <= index_next;
            phase_reg    <= phase_next;
            last_rst_reg <= last_rst_next;
            last_sck_reg <= last_sck_next;
            line_reg     <= line_next;
        end
    end

endmodule

`default_nettype wire

@@ src/ssc_checker.sv @@
// port-level checker for the serial seconds counter rtc and its bind
`default_nettype none

module ssc_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic out_data
);

    // a stalled result beat stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    // a stalled result beat keeps its data
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("result data changed while stalled");

    // an empty result register never blocks the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with result register empty");

    // a fresh result follows a sample accepted earlier through the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result beat without an accepted sample");

endmodule

bind serial_seconds_counter_rtc ssc_checker u_ssc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (result.data_out)
);

`default_nettype wire

@@ verif/tb_serial_seconds_counter_rtc.sv @@
// self-checking testbench for the serial seconds counter rtc with a pin-level model
`timescale 1ns / 100ps

module tb_serial_seconds_counter_rtc;

    typedef enum logic [1:0] {
        RTC_IDLE = 2'd0,
        RTC_CMD  = 2'd1,
        RTC_READ = 2'd2,
        RTC_LOAD = 2'd3
    } rtc_phase_t;

    localparam logic [ssc_pkg::CmdBits-1:0] SPARE_CODE  = 8'h02;
    localparam logic [ssc_pkg::CmdBits-1:0] JUNK_CODE   = 8'hff;
    localparam int unsigned                 STUCK_LIMIT = 2000;
    localparam int unsigned                 MAX_SHOWN   = 10;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [ssc_pkg::CountWidth-1:0] cfg_wr_data;

    ssc_sample_if sample_bus ();
    ssc_result_if result_bus ();

    serial_seconds_counter_rtc uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample      (sample_bus),
        .result      (result_bus),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // rtc state as the host sees it
    logic [ssc_pkg::CountWidth-1:0] rtc_seconds;
    logic [ssc_pkg::CountWidth-1:0] rtc_shift;
    logic [ssc_pkg::CountWidth-1:0] rtc_base;
    logic [ssc_pkg::IndexWidth-1:0] rtc_index;
    rtc_phase_t                     rtc_phase;
    logic                           rtc_last_rst;
    logic                           rtc_last_clk;
    logic                           rtc_line;

    logic        line_expect[$];
    int unsigned mismatch_count;
    int unsigned stuck_cycles;
    int unsigned items_sent;
    int unsigned tick_pct;
    bit          no_idle;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void reset_rtc_model();
        rtc_seconds  = '0;
        rtc_shift    = '0;
        rtc_base     = '0;
        rtc_index    = '0;
        rtc_phase    = RTC_IDLE;
        rtc_last_rst = 1'b1;
        rtc_last_clk = 1'b1;
        rtc_line     = 1'b1;
    endfunction

    function automatic void decode_rtc_command();
        logic [ssc_pkg::CmdBits-1:0] code;
        code = rtc_shift[ssc_pkg::CmdBits-1:0];
        if ((code & ssc_pkg::RW_MASK) == ssc_pkg::READ_CODE)
        begin
            rtc_phase = RTC_READ;
            rtc_shift = rtc_seconds - rtc_base;
            rtc_index = '0;
        end
        else if ((code & ssc_pkg::RW_MASK) == ssc_pkg::LOAD_CODE0
                 || (code & ssc_pkg::RW_MASK) == ssc_pkg::LOAD_CODE1)
        begin
            rtc_phase = RTC_LOAD;
            rtc_shift = '0;
            rtc_index = '0;
        end
        else
        begin
            if ((code & ssc_pkg::RW_MASK) != ssc_pkg::NOP_CODE
                && (code & ssc_pkg::CLR_MASK) == ssc_pkg::CLR_CODE)
                rtc_seconds = '0;
            rtc_phase = RTC_IDLE;
        end
    endfunction

    function automatic void advance_rtc_model(ssc_pkg::sample_t s);
        if (s.second_tick)
            rtc_seconds = rtc_seconds + 1'b1;
        if (s.reset_level != rtc_last_rst)
        begin
            if (s.reset_level)
            begin
                rtc_phase = RTC_CMD;
                rtc_index = '0;
                rtc_shift = '0;
            end
            else
                rtc_phase = RTC_IDLE;
            rtc_last_rst = s.reset_level;
        end
        if (s.drive_data)
            rtc_line = s.data_in;
        if (s.clock_level != rtc_last_clk)
        begin
            if (s.clock_level)
            begin
                if (rtc_phase == RTC_CMD)
                begin
                    rtc_shift[rtc_index[2:0]] = rtc_shift[rtc_index[2:0]] | rtc_line;
                    rtc_index = rtc_index + 1'b1;
                    if (rtc_index > ssc_pkg::CMD_LAST)
                        decode_rtc_command();
                end
                else if (rtc_phase == RTC_LOAD)
                begin
                    rtc_shift[rtc_index[4:0]] = rtc_shift[rtc_index[4:0]] | rtc_line;
                    rtc_index = rtc_index + 1'b1;
                    if (rtc_index > ssc_pkg::WORD_LAST)
                    begin
                        rtc_seconds = rtc_shift;
                        rtc_phase   = RTC_IDLE;
                    end
                end
            end
            else if (rtc_phase == RTC_READ)
            begin
                rtc_line  = rtc_shift[rtc_index[4:0]];
                rtc_index = rtc_index + 1'b1;
                if (rtc_index > ssc_pkg::WORD_LAST)
                    rtc_phase = RTC_IDLE;
            end
            rtc_last_clk = s.clock_level;
        end
        line_expect.push_back(rtc_line);
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (no_idle || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(10, 4);
        return $urandom_range(40, 20);
    endfunction

    task automatic send_sample(input ssc_pkg::sample_t s);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            sample_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_bus.valid       <= 1'b1;
        sample_bus.second_tick <= s.second_tick;
        sample_bus.reset_level <= s.reset_level;
        sample_bus.clock_level <= s.clock_level;
        sample_bus.drive_data  <= s.drive_data;
        sample_bus.data_in     <= s.data_in;
        @(posedge clk);
        while (!sample_bus.ready)
            @(posedge clk);
        advance_rtc_model(s);
    endtask

    task automatic drive_pins(input bit rst, input bit sclk, input bit drive, input bit din);
        ssc_pkg::sample_t s;
        s.second_tick = ($urandom_range(99) < tick_pct);
        s.reset_level = rst;
        s.clock_level = sclk;
        s.drive_data  = drive;
        s.data_in     = din;
        send_sample(s);
        items_sent++;
    endtask

    task automatic begin_transfer();
        drive_pins(1'b0, 1'b1, 1'b0, 1'b0);
        drive_pins(1'b1, 1'b1, 1'b0, 1'b0);
    endtask

    task automatic end_transfer();
        drive_pins(1'b0, 1'b1, 1'b0, 1'b0);
    endtask

    task automatic shift_in_bits(input logic [ssc_pkg::CountWidth-1:0] value,
                                 input int unsigned count);
        for (int unsigned i = 0; i < count; i++)
        begin
            if ($urandom_range(1))
            begin
                drive_pins(1'b1, 1'b0, 1'b1, value[i]);
                drive_pins(1'b1, 1'b1, 1'b0, 1'b0);
            end
            else
            begin
                drive_pins(1'b1, 1'b0, 1'b0, 1'b0);
                drive_pins(1'b1, 1'b1, 1'b1, value[i]);
            end
        end
    endtask

    task automatic shift_in_code(input logic [ssc_pkg::CmdBits-1:0] code,
                                 input int unsigned count);
        shift_in_bits({{(ssc_pkg::CountWidth - ssc_pkg::CmdBits){1'b0}}, code}, count);
    endtask

    // falling edges move read bits out; the host may fight the line in between
    task automatic shift_out_bits(input int unsigned count, input int unsigned meddle_pct);
        for (int unsigned i = 0; i < count; i++)
        begin
            drive_pins(1'b1, 1'b0, 1'b0, 1'b0);
            drive_pins(1'b1, 1'b1, $urandom_range(99) < meddle_pct, 1'($urandom_range(1)));
        end
    endtask

    task automatic load_seconds(input logic [ssc_pkg::CmdBits-1:0] code,
                                input logic [ssc_pkg::CountWidth-1:0] value);
        begin_transfer();
        shift_in_code(code, ssc_pkg::CmdBits);
        shift_in_bits(value, ssc_pkg::CountWidth);
        end_transfer();
    endtask

    task automatic read_seconds(input int unsigned extra_edges, input int unsigned meddle_pct);
        begin_transfer();
        shift_in_code(ssc_pkg::READ_CODE, ssc_pkg::CmdBits);
        shift_out_bits(ssc_pkg::CountWidth + extra_edges, meddle_pct);
        end_transfer();
    endtask

    task automatic simple_command(input logic [ssc_pkg::CmdBits-1:0] code);
        begin_transfer();
        shift_in_code(code, ssc_pkg::CmdBits);
        shift_in_bits($urandom, 3);
        shift_out_bits(2, 0);
        end_transfer();
    endtask

    task automatic wait_until_drained();
        sample_bus.valid <= 1'b0;
        @(posedge clk);
        while (line_expect.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_epoch_base(input logic [ssc_pkg::CountWidth-1:0] value);
        wait_until_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        rtc_base = value;
    endtask

    task automatic test_idle_pins();
        tick_pct = 100;
        drive_pins(1'b0, 1'b0, 1'b1, 1'b0);
        drive_pins(1'b0, 1'b1, 1'b1, 1'b1);
        drive_pins(1'b0, 1'b0, 1'b0, 1'b0);
        drive_pins(1'b0, 1'b1, 1'b1, 1'b0);
        drive_pins(1'b0, 1'b1, 1'b0, 1'b1);
        tick_pct = 0;
    endtask

    task automatic test_load_and_wrap();
        tick_pct = 0;
        load_seconds(ssc_pkg::LOAD_CODE0, '1);
        tick_pct = 100;
        drive_pins(1'b0, 1'b1, 1'b0, 1'b0);
        tick_pct = 0;
        read_seconds(0, 0);
    endtask

    // counter keeps ticking so an ignored clear would show
    task automatic test_ignored_commands();
        tick_pct = 100;
        simple_command(ssc_pkg::NOP_CODE | ssc_pkg::CLR_CODE);
        simple_command(SPARE_CODE);
        simple_command(JUNK_CODE);
        tick_pct = 0;
        read_seconds(0, 0);
    endtask

    task automatic test_clear_command();
        tick_pct = 0;
        simple_command(ssc_pkg::CLR_CODE);
        read_seconds(0, 0);
    endtask

    task automatic test_aborted_transfers();
        begin_transfer();
        shift_in_code(ssc_pkg::CLR_CODE, 5);
        end_transfer();
        begin_transfer();
        shift_in_code(ssc_pkg::LOAD_CODE0, ssc_pkg::CmdBits);
        shift_in_bits('0, 10);
        end_transfer();
        begin_transfer();
        shift_in_code(ssc_pkg::READ_CODE, ssc_pkg::CmdBits);
        shift_out_bits(7, 0);
        end_transfer();
    endtask

    task automatic test_read_line_override();
        tick_pct = 20;
        read_seconds(3, 60);
        tick_pct = 0;
    endtask

    task automatic test_epoch_base_extremes();
        write_epoch_base('1);
        read_seconds(0, 0);
        write_epoch_base('0);
    endtask

    task automatic random_transfer();
        int unsigned pick;
        int unsigned total_bits;
        int unsigned rest;
        logic [ssc_pkg::CmdBits-1:0] code;
        logic [ssc_pkg::CountWidth-1:0] word;
        bit is_read;
        bit is_load;
        pick     = $urandom_range(99);
        tick_pct = $urandom_range(30);
        if (pick < 10)
        begin
            repeat ($urandom_range(15, 4))
                drive_pins(1'($urandom_range(1)), 1'($urandom_range(1)),
                           1'($urandom_range(1)), 1'($urandom_range(1)));
            return;
        end
        code = 8'($urandom);
        if (pick < 45)
            code = (code & ~ssc_pkg::RW_MASK) | ssc_pkg::READ_CODE;
        else if (pick < 75)
            code = (code & ~ssc_pkg::RW_MASK)
                   | (pick[0] ? ssc_pkg::LOAD_CODE0 : ssc_pkg::LOAD_CODE1);
        else if (pick < 85)
            code = (code & ~ssc_pkg::CLR_MASK) | ssc_pkg::CLR_CODE;
        is_read = (code & ssc_pkg::RW_MASK) == ssc_pkg::READ_CODE;
        is_load = (code & ssc_pkg::RW_MASK) == ssc_pkg::LOAD_CODE0
                  || (code & ssc_pkg::RW_MASK) == ssc_pkg::LOAD_CODE1;
        case ($urandom_range(9))
            0: word = '0;
            1: word = '1;
            default: word = $urandom;
        endcase
        if ($urandom_range(99) < 12)
            total_bits = $urandom_range(ssc_pkg::CmdBits + ssc_pkg::CountWidth - 1);
        else if (is_read || is_load)
            total_bits = ssc_pkg::CmdBits + ssc_pkg::CountWidth + $urandom_range(2);
        else
            total_bits = ssc_pkg::CmdBits + $urandom_range(3);
        begin_transfer();
        shift_in_code(code, (total_bits < ssc_pkg::CmdBits) ? total_bits : ssc_pkg::CmdBits);
        rest = (total_bits > ssc_pkg::CmdBits) ? total_bits - ssc_pkg::CmdBits : 0;
        if (is_read)
            shift_out_bits(rest, 10);
        else
            shift_in_bits(word, rest);
        end_transfer();
    endtask

    task automatic test_random_traffic(input int unsigned count, input bit steady);
        int unsigned goal;
        goal    = items_sent + count;
        no_idle = steady;
        while (items_sent < goal)
            random_transfer();
        no_idle = 1'b0;
    endtask

    task automatic note_mismatch(input string what, input logic want, input logic got);
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN)
            $display("%0t: %s: expected data_out %0b, got %0b", $realtime, what, want, got);
    endtask

    // result side with random back-pressure
    initial
    begin
        int unsigned stall_left;
        stall_left = 0;
        result_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left != 0)
            begin
                result_bus.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                result_bus.ready <= 1'b1;
                if (!no_idle && $urandom_range(99) < 25)
                    stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        logic want;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (line_expect.size() == 0)
                note_mismatch("beat with no sample pending", 1'bx, result_bus.data_out);
            else
            begin
                want = line_expect.pop_front();
                if (result_bus.data_out !== want)
                    note_mismatch("data line beat", want, result_bus.data_out);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sample_bus.valid && sample_bus.ready) || (result_bus.valid && result_bus.ready))
                stuck_cycles = 0;
            else
            begin
                stuck_cycles++;
                if (stuck_cycles >= STUCK_LIMIT)
                begin
                    $display("FAIL serial_seconds_counter_rtc");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        rst_n                  <= 1'b0;
        sample_bus.valid       <= 1'b0;
        sample_bus.second_tick <= 1'b0;
        sample_bus.reset_level <= 1'b1;
        sample_bus.clock_level <= 1'b1;
        sample_bus.drive_data  <= 1'b0;
        sample_bus.data_in     <= 1'b0;
        cfg_wr_en              <= 1'b0;
        cfg_wr_data            <= '0;
        mismatch_count = 0;
        stuck_cycles   = 0;
        items_sent     = 0;
        tick_pct       = 0;
        no_idle        = 1'b0;
        reset_rtc_model();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_epoch_base('0);
        test_idle_pins();
        test_load_and_wrap();
        test_ignored_commands();
        test_clear_command();
        test_aborted_transfers();
        test_read_line_override();
        test_epoch_base_extremes();

        write_epoch_base($urandom);
        test_random_traffic(20, 1'b0);
        write_epoch_base('1);
        test_random_traffic(20, 1'b1);
        write_epoch_base('0);
        test_random_traffic(20, 1'b0);

        wait_until_drained();
        repeat (8) @(posedge clk);
        if (line_expect.size() != 0)
            mismatch_count++;
        if (mismatch_count == 0)
            $display("PASS serial_seconds_counter_rtc");
        else
            $display("FAIL serial_seconds_counter_rtc");
        $finish;
    end

endmodule
